/* design/abkf_pkg.sv */
`default_nettype none
package abkf_pkg;

	localparam int FracBits = 24;
	localparam int DataW = 32;
	localparam int NoiseW = 31;
	localparam int DtW = 25;

	// Reset values of the noise registers: round(x * 2^FracBits).
	localparam logic [NoiseW-1:0] QAngleRst = NoiseW'(((64'd1 << FracBits) + 64'd500) / 1000);
	localparam logic [NoiseW-1:0] QBiasRst = NoiseW'(((64'd3 << FracBits) + 64'd500) / 1000);
	localparam logic [NoiseW-1:0] RMeasRst = NoiseW'(((64'd30 << FracBits) + 64'd500) / 1000);

	localparam logic [1:0] RegQAngle = 2'd0;
	localparam logic [1:0] RegQBias = 2'd1;
	localparam logic [1:0] RegRMeas = 2'd2;

	// Shared unit operations.
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam int StepW = 5;

	// Step that forms S, after which the gains are divided out, and the final step.
	localparam logic [StepW-1:0] StepS = StepW'(13);
	localparam logic [StepW-1:0] StepLast = StepW'(26);

	typedef logic signed [DataW-1:0] word_t;

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic [DataW:0] sat32(input logic signed [63:0] v);
		logic [DataW:0] r;
		if (v > 64'sh7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -64'sh8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DataW-1:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/abkf_alu.sv */
`default_nettype none
// Shared add, subtract and fractional multiply unit, result registered.
module abkf_alu (
	input  wire                  clk,
	input  abkf_pkg::alu_op_t    op,
	input  abkf_pkg::word_t      a,
	input  abkf_pkg::word_t      b,
	output abkf_pkg::word_t      res_q,
	output logic                 sat_q
);
	logic signed [63:0] wide;
	logic signed [63:0] prod;
	logic [abkf_pkg::DataW:0] s;

	// One operation per cycle; the product shift floors by the arithmetic shift.
	always_comb begin
		prod = 64'(a) * 64'(b);
		unique case (op)
			abkf_pkg::OP_ADD: wide = 64'(a) + 64'(b);
			abkf_pkg::OP_SUB: wide = 64'(a) - 64'(b);
			abkf_pkg::OP_MUL: wide = prod >>> abkf_pkg::FracBits;
			default:          wide = 64'(a) + 64'(b);
		endcase
		s = abkf_pkg::sat32(wide);
	end

	always_ff @(posedge clk) begin
		res_q <= s[abkf_pkg::DataW-1:0];
		sat_q <= s[abkf_pkg::DataW];
	end
endmodule
`default_nettype wire

/* design/abkf_div.sv */
`default_nettype none
// Restoring divider: (num * 2^FracBits) / den, truncated toward zero, saturated.
// One quotient bit per cycle; den is positive.
module abkf_div (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  abkf_pkg::word_t  num,
	input  abkf_pkg::word_t  den,
	output logic             busy,
	output abkf_pkg::word_t  quo_q,
	output logic             sat_q
);
	localparam int NumW = abkf_pkg::DataW + abkf_pkg::FracBits;
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] dvd_q;
	logic [NumW-1:0] qb_q;
	logic [abkf_pkg::DataW:0] rem_q;
	logic [abkf_pkg::DataW-1:0] den_q;
	logic neg_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic [abkf_pkg::DataW:0] rem_sh;
	logic [abkf_pkg::DataW:0] rem_try;
	logic qbit;
	logic [NumW-1:0] qb_nx;
	logic signed [NumW:0] sq;
	logic [abkf_pkg::DataW:0] fin;
	logic [abkf_pkg::DataW-1:0] mag;

	assign busy = busy_q;

	// The final quotient is formed from the next quotient bits, so it is
	// registered together with the last bit and is ready as busy falls.
	always_comb begin
		rem_sh = {rem_q[abkf_pkg::DataW-1:0], dvd_q[NumW-1]};
		rem_try = rem_sh - {1'b0, den_q};
		qbit = !rem_try[abkf_pkg::DataW];
		qb_nx = {qb_q[NumW-2:0], qbit};
		mag = num[abkf_pkg::DataW-1] ? 32'(-num) : num;
		if (neg_q) begin
			sq = -$signed({1'b0, qb_nx});
		end else begin
			sq = $signed({1'b0, qb_nx});
		end
		fin = abkf_pkg::sat32(64'(sq));
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CntW'(NumW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: one bit a cycle, result captured on the last step.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {abkf_pkg::FracBits{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			qb_q <= '0;
			neg_q <= num[abkf_pkg::DataW-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NumW-2:0], 1'b0};
			qb_q <= qb_nx;
			if (qbit) begin
				rem_q <= rem_try;
			end else begin
				rem_q <= rem_sh;
			end
			if (cnt_q == CntW'(1)) begin
				quo_q <= fin[abkf_pkg::DataW-1:0];
				sat_q <= fin[abkf_pkg::DataW];
			end
		end
	end
endmodule
`default_nettype wire

/* design/angle_bias_kalman_filter.sv */
`default_nettype none
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | measured_angle, measured_rate, time_step
// out     | output    | valid / stall | angle_estimate, bias_estimate, overflow_flag
// cfg     | input     | valid / ready | cfg_index, cfg_data
//
// A result is offered once its sample has passed 27 steps of the shared
// add/multiply unit, each one presenting operands and then writing back,
// two divisions (launch, 56 quotient bits, take) and the output load.
// A non-positive S skips both divisions.
// Reset clears the filter state and loads the default noise values.
// The input stalls until the result is loaded, so no new sample is taken
// while one is in work; a held result stalls a finished sample until it
// has left. Configuration is always ready.
module angle_bias_kalman_filter (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  measured_angle,
	input  wire signed [31:0]  measured_rate,
	input  wire [24:0]         time_step,
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] angle_estimate,
	output logic signed [31:0] bias_estimate,
	output logic               overflow_flag,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [30:0]         cfg_data
);
	abkf_pkg::state_t state_q, state_d;
	logic [abkf_pkg::StepW-1:0] step_q;
	logic ph_q;
	logic [abkf_pkg::NoiseW-1:0] qa_q, qb_q, rm_q;
	abkf_pkg::word_t ang_q, bia_q, c00_q, c01_q, c10_q, c11_q;
	abkf_pkg::word_t z_q, rate_q, dt_q, t_q, dp_q, s_q, k0_q, k1_q, y_q;
	logic flag_q;
	logic div_sel_q, div_wait_q;
	logic out_valid_q;
	abkf_pkg::alu_op_t op;
	abkf_pkg::word_t a, b, r;
	logic rsat;
	logic div_start, div_busy, div_sat;
	abkf_pkg::word_t div_q;
	logic in_take, out_take, step_end, s_bad, div_take, publish;
	abkf_pkg::word_t qa_w, qb_w, rm_w;

	assign qa_w = abkf_pkg::word_t'({1'b0, qa_q});
	assign qb_w = abkf_pkg::word_t'({1'b0, qb_q});
	assign rm_w = abkf_pkg::word_t'({1'b0, rm_q});
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign in_take = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign step_end = (state_q == abkf_pkg::ST_RUN) && ph_q;
	assign s_bad = s_q[abkf_pkg::DataW-1] || (s_q == '0);
	assign div_take = div_wait_q && !div_busy;

	abkf_alu u_alu (
		.clk(clk), .op(op), .a(a), .b(b), .res_q(r), .sat_q(rsat)
	);

	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_sel_q ? c10_q : c00_q), .den(s_q),
		.busy(div_busy), .quo_q(div_q), .sat_q(div_sat)
	);

	// Operand selection for each step of the sequence.
	always_comb begin
		op = abkf_pkg::OP_ADD;
		a = '0;
		b = '0;
		case (step_q)
			5'd0:  begin op = abkf_pkg::OP_SUB; a = rate_q; b = bia_q; end
			5'd1:  begin op = abkf_pkg::OP_MUL; a = dt_q;   b = t_q;   end
			5'd2:  begin op = abkf_pkg::OP_ADD; a = ang_q;  b = t_q;   end
			5'd3:  begin op = abkf_pkg::OP_MUL; a = dt_q;   b = c11_q; end
			5'd4:  begin op = abkf_pkg::OP_SUB; a = dp_q;   b = c01_q; end
			5'd5:  begin op = abkf_pkg::OP_SUB; a = t_q;    b = c10_q; end
			5'd6:  begin op = abkf_pkg::OP_ADD; a = t_q;    b = qa_w;  end
			5'd7:  begin op = abkf_pkg::OP_MUL; a = dt_q;   b = t_q;   end
			5'd8:  begin op = abkf_pkg::OP_ADD; a = c00_q;  b = t_q;   end
			5'd9:  begin op = abkf_pkg::OP_SUB; a = c01_q;  b = dp_q;  end
			5'd10: begin op = abkf_pkg::OP_SUB; a = c10_q;  b = dp_q;  end
			5'd11: begin op = abkf_pkg::OP_MUL; a = qb_w;   b = dt_q;  end
			5'd12: begin op = abkf_pkg::OP_ADD; a = c11_q;  b = t_q;   end
			5'd13: begin op = abkf_pkg::OP_ADD; a = c00_q;  b = rm_w;  end
			5'd14: begin op = abkf_pkg::OP_SUB; a = z_q;    b = ang_q; end
			5'd15: begin op = abkf_pkg::OP_MUL; a = k0_q;   b = y_q;   end
			5'd16: begin op = abkf_pkg::OP_MUL; a = k1_q;   b = y_q;   end
			5'd17: begin op = abkf_pkg::OP_ADD; a = ang_q;  b = t_q;   end
			5'd18: begin op = abkf_pkg::OP_ADD; a = bia_q;  b = dp_q;  end
			5'd19: begin op = abkf_pkg::OP_MUL; a = k0_q;   b = c00_q; end
			5'd20: begin op = abkf_pkg::OP_MUL; a = k1_q;   b = c00_q; end
			5'd21: begin op = abkf_pkg::OP_SUB; a = c00_q;  b = t_q;   end
			5'd22: begin op = abkf_pkg::OP_SUB; a = c10_q;  b = dp_q;  end
			5'd23: begin op = abkf_pkg::OP_MUL; a = k0_q;   b = c01_q; end
			5'd24: begin op = abkf_pkg::OP_MUL; a = k1_q;   b = c01_q; end
			5'd25: begin op = abkf_pkg::OP_SUB; a = c01_q;  b = t_q;   end
			5'd26: begin op = abkf_pkg::OP_SUB; a = c11_q;  b = dp_q;  end
			default: begin op = abkf_pkg::OP_ADD; a = '0;   b = '0;    end
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abkf_pkg::ST_IDLE: if (in_take) state_d = abkf_pkg::ST_RUN;
			abkf_pkg::ST_RUN: begin
				if (step_end && step_q == abkf_pkg::StepS) state_d = abkf_pkg::ST_DIV;
				else if (step_end && step_q == abkf_pkg::StepLast) state_d = abkf_pkg::ST_DONE;
			end
			abkf_pkg::ST_DIV: if (s_bad || (div_take && div_sel_q)) state_d = abkf_pkg::ST_RUN;
			abkf_pkg::ST_DONE: if (publish) state_d = abkf_pkg::ST_IDLE;
			default: state_d = abkf_pkg::ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_stall = (state_q != abkf_pkg::ST_IDLE);
		div_start = (state_q == abkf_pkg::ST_DIV) && !s_bad && !div_wait_q;
		publish = (state_q == abkf_pkg::ST_DONE) && (!out_valid_q || out_take);
	end

	// Sequencer, filter state and output register. Each step presents its
	// operands with ph low and writes the unit's registered result with ph high.
	// The divide phase launches k0, takes it, launches k1 and takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abkf_pkg::ST_IDLE;
			step_q <= '0;
			ph_q <= 1'b0;
			div_sel_q <= 1'b0;
			div_wait_q <= 1'b0;
			qa_q <= abkf_pkg::QAngleRst;
			qb_q <= abkf_pkg::QBiasRst;
			rm_q <= abkf_pkg::RMeasRst;
			ang_q <= '0; bia_q <= '0;
			c00_q <= '0; c01_q <= '0; c10_q <= '0; c11_q <= '0;
			t_q <= '0; dp_q <= '0; s_q <= '0; y_q <= '0;
			k0_q <= '0; k1_q <= '0;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			angle_estimate <= '0;
			bias_estimate <= '0;
			overflow_flag <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					abkf_pkg::RegQAngle: qa_q <= cfg_data;
					abkf_pkg::RegQBias:  qb_q <= cfg_data;
					abkf_pkg::RegRMeas:  rm_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_take) begin
				step_q <= '0;
				ph_q <= 1'b0;
				flag_q <= 1'b0;
				div_sel_q <= 1'b0;
				div_wait_q <= 1'b0;
			end else if (state_q == abkf_pkg::ST_RUN) begin
				ph_q <= !ph_q;
				if (ph_q) begin
					flag_q <= flag_q | rsat;
					case (step_q)
						5'd2:  ang_q <= r;
						5'd3:  dp_q <= r;
						5'd8:  c00_q <= r;
						5'd9:  c01_q <= r;
						5'd10: c10_q <= r;
						5'd12: c11_q <= r;
						5'd13: s_q <= r;
						5'd14: y_q <= r;
						5'd16: dp_q <= r;
						5'd17: ang_q <= r;
						5'd18: bia_q <= r;
						5'd20: dp_q <= r;
						5'd21: c00_q <= r;
						5'd22: c10_q <= r;
						5'd24: dp_q <= r;
						5'd25: c01_q <= r;
						5'd26: c11_q <= r;
						default: t_q <= r;
					endcase
					if (step_q == abkf_pkg::StepLast) begin
						step_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
			end else if (state_q == abkf_pkg::ST_DIV) begin
				// A non-positive S leaves both gains at zero.
				if (s_bad) begin
					k0_q <= '0; k1_q <= '0;
					flag_q <= 1'b1;
				end else if (!div_wait_q) begin
					div_wait_q <= 1'b1;
				end else if (!div_busy) begin
					div_wait_q <= 1'b0;
					flag_q <= flag_q | div_sat;
					if (div_sel_q) begin
						k1_q <= div_q;
					end else begin
						k0_q <= div_q;
						div_sel_q <= 1'b1;
					end
				end
			end
			// Result register: loaded once it is free or being moved out.
			if (publish) begin
				angle_estimate <= ang_q;
				bias_estimate <= bia_q;
				overflow_flag <= flag_q;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (in_take) begin
			z_q <= measured_angle;
			rate_q <= measured_rate;
			dt_q <= abkf_pkg::word_t'({7'd0, time_step});
		end
	end

	// Assertions.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != abkf_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (state_q == abkf_pkg::ST_DIV))
		else $error("divider started outside divide phase");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(angle_estimate) && $stable(bias_estimate)
		&& $stable(overflow_flag)))
		else $error("stalled result changed");
endmodule
`default_nettype wire

/* verif/abkf_checker.sv */
`default_nettype none
module abkf_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                in_stall,
	input  wire signed [31:0]  measured_angle,
	input  wire signed [31:0]  measured_rate,
	input  wire [24:0]         time_step,
	input  wire                out_valid,
	input  wire                out_stall,
	input  wire signed [31:0]  angle_estimate,
	input  wire signed [31:0]  bias_estimate,
	input  wire                overflow_flag,
	input  wire                cfg_valid,
	input  wire                cfg_ready,
	input  wire [1:0]          cfg_index,
	input  wire [30:0]         cfg_data,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] bias;
		logic               flag;
	} estimate_t;

	estimate_t estimates_due[$];

	// Filter state and noise settings, kept as wide signed values.
	longint est_angle, est_bias, p00, p01, p10, p11;
	longint q_angle, q_bias, r_meas;
	bit saturated;

	function automatic longint clip(longint v);
		if (v > 64'sd2147483647) begin
			saturated = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			saturated = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Fixed-point product, floored, then saturated.
	function automatic longint fmul(longint a, longint b);
		return clip((a * b) >>> abkf_pkg::FracBits);
	endfunction

	function automatic longint fdiv(longint a, longint d);
		return clip((a <<< abkf_pkg::FracBits) / d);
	endfunction

	// One full filter step on an accepted sample.
	function automatic estimate_t kalman_step(longint z, longint rate, longint dt);
		longint dp11, s, k0, k1, y, t00, t01;
		estimate_t e;
		saturated = 1'b0;
		est_angle = clip(est_angle + fmul(dt, clip(rate - est_bias)));
		dp11 = fmul(dt, p11);
		p00 = clip(p00 + fmul(dt, clip(clip(clip(dp11 - p01) - p10) + q_angle)));
		p01 = clip(p01 - dp11);
		p10 = clip(p10 - dp11);
		p11 = clip(p11 + fmul(q_bias, dt));
		s = clip(p00 + r_meas);
		// A non-positive innovation variance disables the correction.
		if (s <= 0) begin
			saturated = 1'b1;
			k0 = 0;
			k1 = 0;
		end else begin
			k0 = fdiv(p00, s);
			k1 = fdiv(p10, s);
		end
		y = clip(z - est_angle);
		est_angle = clip(est_angle + fmul(k0, y));
		est_bias = clip(est_bias + fmul(k1, y));
		t00 = p00;
		t01 = p01;
		p00 = clip(p00 - fmul(k0, t00));
		p01 = clip(p01 - fmul(k0, t01));
		p10 = clip(p10 - fmul(k1, t00));
		p11 = clip(p11 - fmul(k1, t01));
		e.angle = est_angle[31:0];
		e.bias = est_bias[31:0];
		e.flag = saturated;
		return e;
	endfunction

	assign pending = estimates_due.size();

	// Watch the configuration and input channels, predict, and check results.
	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		if (!arst_n) begin
			est_angle = 0; est_bias = 0;
			p00 = 0; p01 = 0; p10 = 0; p11 = 0;
			q_angle = abkf_pkg::QAngleRst;
			q_bias = abkf_pkg::QBiasRst;
			r_meas = abkf_pkg::RMeasRst;
			estimates_due.delete();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					abkf_pkg::RegQAngle: q_angle = cfg_data;
					abkf_pkg::RegQBias: q_bias = cfg_data;
					abkf_pkg::RegRMeas: r_meas = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				estimates_due.push_back(kalman_step(measured_angle, measured_rate,
					time_step));
			if (out_valid && !out_stall) begin
				if (estimates_due.size() == 0) begin
					$display("%t: unexpected result transfer angle %h bias %h flag %b",
						$time, angle_estimate, bias_estimate, overflow_flag);
					fail_count <= fail_count + 1;
				end else begin
					want = estimates_due.pop_front();
					if (want.angle !== angle_estimate || want.bias !== bias_estimate ||
						want.flag !== overflow_flag) begin
						$display({"%t: mismatch angle exp %h got %h, ",
							"bias exp %h got %h, flag exp %b got %b"},
							$time, want.angle, angle_estimate, want.bias, bias_estimate,
							want.flag, overflow_flag);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* verif/angle_bias_kalman_filter_tb.sv */
`default_nettype none
module angle_bias_kalman_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] measured_angle = '0;
	logic signed [31:0] measured_rate = '0;
	logic [24:0] time_step = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] angle_estimate, bias_estimate;
	logic overflow_flag;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	int fail_count, pending;
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int cycles = 0;

	localparam int CycleLimit = 2000000;
	localparam int DrainCycles = 300;

	angle_bias_kalman_filter DUT (.*);

	abkf_checker checker_i (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// The run ends here, as failed, when the cycle count reaches CycleLimit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_request && hold == 0)
				hold = 1000;
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
				if (hold == 0)
					hold_request = 1'b0;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 37);
			end
		end
	end

	task automatic send_sample(logic [31:0] z, logic [31:0] rate, logic [24:0] dt);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		measured_angle <= z;
		measured_rate <= rate;
		time_step <= dt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Registers change only once the block has drained.
	task automatic write_reg(logic [1:0] idx, logic [30:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_samples(int count);
		logic [31:0] z, rate;
		logic [24:0] dt;
		repeat (count) begin
			if ($urandom_range(99) < 80) begin
				// Plausible sensor data: small angles, rates and time steps.
				z = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
				rate = $signed($urandom_range(0, 1 << 28)) - (1 << 27);
				dt = 25'($urandom_range(0, 1 << 20));
			end else begin
				z = $urandom;
				rate = $urandom;
				dt = 25'($urandom_range(0, (1 << 25) - 1));
			end
			send_sample(z, rate, dt);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no measurement noise and no time elapsed, S stays at zero.
		write_reg(abkf_pkg::RegRMeas, 31'd0);
		send_sample(32'd0, 32'd0, 25'd0);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 25'd0);
		write_reg(abkf_pkg::RegRMeas, abkf_pkg::RMeasRst);

		// Field extremes, including time steps beyond one second.
		send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 25'd16777216);
		send_sample(32'h8000_0000, 32'h8000_0000, 25'd16777216);
		send_sample(32'h0000_0000, 32'hFFFF_FFFF, 25'h1FF_FFFF);
		send_sample(32'hFFFF_FFFF, 32'h0000_0000, 25'h1FF_FFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 25'd1);
		send_sample(32'h5555_5555, 32'hAAAA_AAAA, 25'h0AA_AAAA);
		send_sample(32'hAAAA_AAAA, 32'h5555_5555, 25'h155_5555);
		send_sample(32'h0100_0000, 32'h0000_0000, 25'd167772);
		send_sample(32'h0000_0000, 32'h0100_0000, 25'd167772);
		send_sample(32'd0, 32'd0, 25'd0);

		// Default noise, a calm stretch, then the long result hold-off.
		calm = 1'b1;
		random_samples(150);
		calm = 1'b0;
		hold_request = 1'b1;
		random_samples(200);

		// Largest noise values.
		write_reg(abkf_pkg::RegQAngle, 31'h7FFF_FFFF);
		write_reg(abkf_pkg::RegQBias, 31'h7FFF_FFFF);
		write_reg(abkf_pkg::RegRMeas, 31'h7FFF_FFFF);
		random_samples(320);

		// No noise at all.
		write_reg(abkf_pkg::RegQAngle, 31'd0);
		write_reg(abkf_pkg::RegQBias, 31'd0);
		write_reg(abkf_pkg::RegRMeas, 31'd0);
		random_samples(320);

		// Random settings; an index past the last register is ignored.
		write_reg(abkf_pkg::RegQAngle, 31'($urandom_range(0, 1 << 20)));
		write_reg(abkf_pkg::RegQBias, 31'($urandom_range(0, 1 << 20)));
		write_reg(abkf_pkg::RegRMeas, 31'($urandom_range(0, 1 << 23)));
		write_reg(2'd3, 31'h7FFF_FFFF);
		random_samples(320);

		write_reg(abkf_pkg::RegQAngle, 31'($urandom));
		write_reg(abkf_pkg::RegQBias, 31'($urandom));
		write_reg(abkf_pkg::RegRMeas, 31'($urandom));
		random_samples(330);

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
